@@ hw/rtl/brme_pkg.sv @@
// shared widths, sizes and command codes of the byte register machine executor
`default_nettype none
package brme_pkg;

    localparam int MEM_BYTES = 1024;
    localparam int NUM_REGS  = 8;
    localparam int MEM_AW    = $clog2(MEM_BYTES);
    localparam int REG_AW    = $clog2(NUM_REGS);

    localparam int DATA_W = 8;
    localparam int CMD_W  = 4;
    localparam int PC_W   = 7;
    localparam int NPC_W  = 8;
    localparam int COND_W = 3;
    localparam int PLEN_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PRELOAD = 4'd0,
        CMD_STORE   = 4'd1,
        CMD_LOAD    = 4'd2,
        CMD_ADD     = 4'd3,
        CMD_SUB     = 4'd4,
        CMD_MUL     = 4'd5,
        CMD_JUMP    = 4'd6,
        CMD_BRANCH  = 4'd7,
        CMD_PRINT   = 4'd8,
        CMD_READ    = 4'd9
    } t_cmd;

    typedef enum logic [COND_W-1:0] {
        COND_EQ = 3'd0,
        COND_LT = 3'd1,
        COND_GT = 3'd2,
        COND_LE = 3'd3,
        COND_GE = 3'd4
    } t_cond;

endpackage
`default_nettype wire

@@ hw/rtl/brme_ram.sv @@
// generic single write port ram with registered read and read enable
`default_nettype none
module brme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/byte_register_machine_executor.sv @@
// byte register machine executor: one decoded instruction per request
//
// usage:
//   input channel (i_in_valid / o_in_stall) takes one decoded instruction per
//   request; output channel (o_out_valid / i_out_stall) gives one result per
//   instruction: next pc, halted flag and an optional printed value.
//   the config channel (i_cfg_valid / o_cfg_ready) writes program_length and
//   is always ready; write it only while no instruction is in flight.
// a result enters the output register when its instruction leaves the execute
//   stage (register and memory reads at the accept edge, execute in the cycle
//   after). throughput: one instruction per cycle while the receiver does not
//   stall; the register file and data memory reads are issued at accept and a
//   just-executed write is forwarded, so a load result can feed the very next instruction.
// reset: synchronous, active low. afterwards a clearing pass zeroes the data
//   memory and register file, one address a cycle; o_in_stall stays high
//   during that pass. program_length resets to 0.
// receiver stall: the result holds in the output register, the execute stage
//   holds behind it and then o_in_stall rises.
`default_nettype none
module byte_register_machine_executor (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [brme_pkg::PLEN_W-1:0]         i_cfg_program_length,
    // instruction channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [brme_pkg::CMD_W-1:0]          i_command,
    input  wire logic [brme_pkg::PC_W-1:0]           i_pc,
    input  wire logic [brme_pkg::REG_AW-1:0]         i_dest_reg,
    input  wire logic [brme_pkg::REG_AW-1:0]         i_src_a_reg,
    input  wire logic [brme_pkg::REG_AW-1:0]         i_src_b_reg,
    input  wire logic [brme_pkg::MEM_AW-1:0]         i_mem_addr,
    input  wire logic [brme_pkg::COND_W-1:0]         i_condition,
    input  wire logic [brme_pkg::PC_W-1:0]           i_target,
    input  wire logic signed [brme_pkg::DATA_W-1:0]  i_data_value,
    // result channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [brme_pkg::NPC_W-1:0]               o_next_pc,
    output logic                                     o_halted,
    output logic                                     o_print_valid,
    output logic signed [brme_pkg::DATA_W-1:0]       o_print_value
);

    import brme_pkg::*;

    // clearing pass
    logic              r_clr_busy;
    logic [MEM_AW-1:0] r_clr_cnt;

    logic [PLEN_W-1:0] r_plen;

    // execute stage
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic [PC_W-1:0]   r_s1_pc;
    logic [REG_AW-1:0] r_s1_dest;
    logic [MEM_AW-1:0] r_s1_addr;
    logic [COND_W-1:0] r_s1_cond;
    logic [PC_W-1:0]   r_s1_target;
    logic [DATA_W-1:0] r_s1_data;

    // forwarding of the write done at the accept edge
    logic              r_fwd_a_hit;
    logic              r_fwd_b_hit;
    logic [DATA_W-1:0] r_fwd_reg_data;
    logic              r_fwd_mem_hit;
    logic [DATA_W-1:0] r_fwd_mem_data;

    // output register
    logic              r_out_valid;
    logic [NPC_W-1:0]  r_out_next_pc;
    logic              r_out_halted;
    logic              r_out_print_valid;
    logic [DATA_W-1:0] r_out_print_value;

    logic              accept;
    logic              s1_fire;
    logic [REG_AW-1:0] rd_addr_a;
    logic              in_is_arith;

    logic [DATA_W-1:0] rf_a_rdata;
    logic [DATA_W-1:0] rf_b_rdata;
    logic [DATA_W-1:0] mem_rdata;

    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] ld_data;
    logic [DATA_W-1:0] prod;

    logic              s1_reg_we;
    logic [DATA_W-1:0] s1_reg_wdata;
    logic              s1_mem_we;
    logic [DATA_W-1:0] s1_mem_wdata;
    logic [NPC_W-1:0]  s1_next_pc;
    logic              s1_print;
    logic              br_holds;
    logic              br_known;

    logic              rf_we;
    logic [REG_AW-1:0] rf_waddr;
    logic [DATA_W-1:0] rf_wdata;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    assign s1_fire    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_fire);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign in_is_arith = (i_command == CMD_ADD) || (i_command == CMD_SUB)
                      || (i_command == CMD_MUL);
    assign rd_addr_a   = in_is_arith ? i_src_a_reg : i_dest_reg;

    // ram write ports: clearing pass or execute stage
    assign rf_we     = r_clr_busy || (s1_fire && s1_reg_we);
    assign rf_waddr  = r_clr_busy ? r_clr_cnt[REG_AW-1:0] : r_s1_dest;
    assign rf_wdata  = r_clr_busy ? '0 : s1_reg_wdata;
    assign mem_we    = r_clr_busy || (s1_fire && s1_mem_we);
    assign mem_waddr = r_clr_busy ? r_clr_cnt : r_s1_addr;
    assign mem_wdata = r_clr_busy ? '0 : s1_mem_wdata;

    // two copies of the register file give two read ports
    brme_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (accept),
        .i_raddr (rd_addr_a),
        .o_rdata (rf_a_rdata)
    );

    brme_ram #(.WIDTH(DATA_W), .DEPTH(NUM_REGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_re    (accept),
        .i_raddr (i_src_b_reg),
        .o_rdata (rf_b_rdata)
    );

    brme_ram #(.WIDTH(DATA_W), .DEPTH(MEM_BYTES)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (accept),
        .i_raddr (i_mem_addr),
        .o_rdata (mem_rdata)
    );

    assign opa     = r_fwd_a_hit   ? r_fwd_reg_data : rf_a_rdata;
    assign opb     = r_fwd_b_hit   ? r_fwd_reg_data : rf_b_rdata;
    assign ld_data = r_fwd_mem_hit ? r_fwd_mem_data : mem_rdata;
    assign prod    = DATA_W'(opa * opb);

    always_comb begin
        br_known = 1'b1;
        br_holds = 1'b0;
        unique case (r_s1_cond)
            COND_EQ: br_holds = (opa == opb);
            COND_LT: br_holds = ($signed(opa) <  $signed(opb));
            COND_GT: br_holds = ($signed(opa) >  $signed(opb));
            COND_LE: br_holds = ($signed(opa) <= $signed(opb));
            COND_GE: br_holds = ($signed(opa) >= $signed(opb));
            default: br_known = 1'b0;
        endcase
    end

    always_comb begin
        s1_reg_we    = 1'b0;
        s1_reg_wdata = r_s1_data;
        s1_mem_we    = 1'b0;
        s1_mem_wdata = r_s1_data;
        s1_print     = 1'b0;
        s1_next_pc   = NPC_W'(r_s1_pc) + NPC_W'(1);
        unique case (r_s1_cmd)
            CMD_PRELOAD: begin
                s1_mem_we  = 1'b1;
                s1_next_pc = NPC_W'(r_s1_pc);
            end
            CMD_STORE: begin
                s1_mem_we    = 1'b1;
                s1_mem_wdata = opa;
            end
            CMD_LOAD: begin
                s1_reg_we    = 1'b1;
                s1_reg_wdata = ld_data;
            end
            CMD_ADD: begin
                s1_reg_we    = 1'b1;
                s1_reg_wdata = opa + opb;
            end
            CMD_SUB: begin
                s1_reg_we    = 1'b1;
                s1_reg_wdata = opa - opb;
            end
            CMD_MUL: begin
                s1_reg_we    = 1'b1;
                s1_reg_wdata = prod;
            end
            CMD_JUMP: begin
                s1_next_pc = NPC_W'(r_s1_target);
            end
            CMD_BRANCH: begin
                // taken when the test fails
                if (br_known && !br_holds) begin
                    s1_next_pc = NPC_W'(r_s1_target);
                end
            end
            CMD_PRINT: begin
                s1_print = 1'b1;
            end
            CMD_READ: begin
                s1_reg_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy  <= 1'b1;
            r_clr_cnt   <= '0;
            r_plen      <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_cnt <= r_clr_cnt + MEM_AW'(1);
                if (r_clr_cnt == MEM_AW'(MEM_BYTES - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_plen <= i_cfg_program_length;
            end
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd    <= i_command;
            r_s1_pc     <= i_pc;
            r_s1_dest   <= i_dest_reg;
            r_s1_addr   <= i_mem_addr;
            r_s1_cond   <= i_condition;
            r_s1_target <= i_target;
            r_s1_data   <= i_data_value;
            // the ram reads at this edge miss the write done at the same edge
            r_fwd_a_hit    <= s1_fire && s1_reg_we && (r_s1_dest == rd_addr_a);
            r_fwd_b_hit    <= s1_fire && s1_reg_we && (r_s1_dest == i_src_b_reg);
            r_fwd_reg_data <= s1_reg_wdata;
            r_fwd_mem_hit  <= s1_fire && s1_mem_we && (r_s1_addr == i_mem_addr);
            r_fwd_mem_data <= s1_mem_wdata;
        end
        if (s1_fire) begin
            r_out_next_pc     <= s1_next_pc;
            r_out_halted      <= (s1_next_pc >= r_plen);
            r_out_print_valid <= s1_print;
            r_out_print_value <= s1_print ? opa : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out_next_pc;
    assign o_halted      = r_out_halted;
    assign o_print_valid = r_out_print_valid;
    assign o_print_value = r_out_print_value;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// self-checking testbench for the byte register machine executor
`timescale 1ns / 1ps
module tb;
    import brme_pkg::*;

    localparam logic [CMD_W-1:0]  CMD_UNDEF_FIRST  = 4'd10;
    localparam logic [CMD_W-1:0]  CMD_UNDEF_LAST   = 4'd15;
    localparam logic [COND_W-1:0] COND_UNDEF_FIRST = 3'd5;
    localparam logic [COND_W-1:0] COND_UNDEF_LAST  = 3'd7;
    localparam int ITEMS_PER_PHASE = 143;
    localparam int NUM_PHASES      = 10;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PC_W-1:0]   pc;
        logic [REG_AW-1:0] rd;
        logic [REG_AW-1:0] ra;
        logic [REG_AW-1:0] rb;
        logic [MEM_AW-1:0] addr;
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic [DATA_W-1:0] data;
    } t_instr;

    typedef struct packed {
        logic [NPC_W-1:0]  next_pc;
        logic              halted;
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
    } t_outcome;

    typedef struct packed {
        t_instr   ins;
        logic     typed;
        t_outcome want;
    } t_plan_row;

    logic                      i_clk;
    logic                      i_rst_n              = 1'b0;
    logic                      i_cfg_valid          = 1'b0;
    logic [PLEN_W-1:0]         i_cfg_program_length = '0;
    logic                      i_in_valid           = 1'b0;
    logic [CMD_W-1:0]          i_command            = '0;
    logic [PC_W-1:0]           i_pc                 = '0;
    logic [REG_AW-1:0]         i_dest_reg           = '0;
    logic [REG_AW-1:0]         i_src_a_reg          = '0;
    logic [REG_AW-1:0]         i_src_b_reg          = '0;
    logic [MEM_AW-1:0]         i_mem_addr           = '0;
    logic [COND_W-1:0]         i_condition          = '0;
    logic [PC_W-1:0]           i_target             = '0;
    logic signed [DATA_W-1:0]  i_data_value         = '0;
    logic                      i_out_stall          = 1'b0;
    logic                      o_cfg_ready;
    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [NPC_W-1:0]          o_next_pc;
    logic                      o_halted;
    logic                      o_print_valid;
    logic signed [DATA_W-1:0]  o_print_value;

    // architectural state of the machine as the checker sees it
    logic [DATA_W-1:0] arch_regs [NUM_REGS];
    logic [DATA_W-1:0] arch_mem  [MEM_BYTES];
    logic [PLEN_W-1:0] prog_len;
    logic [PC_W-1:0]   flow_pc;

    t_outcome  pending_results [$];
    t_plan_row directed_plan [$];
    int        mismatches = 0;

    byte_register_machine_executor dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_program_length (i_cfg_program_length),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_command            (i_command),
        .i_pc                 (i_pc),
        .i_dest_reg           (i_dest_reg),
        .i_src_a_reg          (i_src_a_reg),
        .i_src_b_reg          (i_src_b_reg),
        .i_mem_addr           (i_mem_addr),
        .i_condition          (i_condition),
        .i_target             (i_target),
        .i_data_value         (i_data_value),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_next_pc            (o_next_pc),
        .o_halted             (o_halted),
        .o_print_valid        (o_print_valid),
        .o_print_value        (o_print_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic t_outcome execute_instr(t_instr x);
        t_outcome                 o;
        logic signed [DATA_W-1:0] lhs;
        logic signed [DATA_W-1:0] rhs;
        logic                     known;
        logic                     holds;
        o       = '0;
        o.next_pc = NPC_W'(x.pc) + 1'b1;
        lhs     = arch_regs[x.rd];
        rhs     = arch_regs[x.rb];
        case (x.cmd)
            CMD_PRELOAD: begin
                arch_mem[x.addr] = x.data;
                o.next_pc = NPC_W'(x.pc);
            end
            CMD_STORE: arch_mem[x.addr] = arch_regs[x.rd];
            CMD_LOAD:  arch_regs[x.rd] = arch_mem[x.addr];
            CMD_ADD:   arch_regs[x.rd] = arch_regs[x.ra] + arch_regs[x.rb];
            CMD_SUB:   arch_regs[x.rd] = arch_regs[x.ra] - arch_regs[x.rb];
            CMD_MUL:   arch_regs[x.rd] = arch_regs[x.ra] * arch_regs[x.rb];
            CMD_JUMP:  o.next_pc = NPC_W'(x.target);
            CMD_BRANCH: begin
                known = 1'b1;
                holds = 1'b0;
                case (x.cond)
                    COND_EQ: holds = (lhs == rhs);
                    COND_LT: holds = (lhs < rhs);
                    COND_GT: holds = (lhs > rhs);
                    COND_LE: holds = (lhs <= rhs);
                    COND_GE: holds = (lhs >= rhs);
                    default: known = 1'b0;
                endcase
                // taken when the test fails, unknown tests fall through
                if (known && !holds) begin
                    o.next_pc = NPC_W'(x.target);
                end
            end
            CMD_PRINT: begin
                o.print_valid = 1'b1;
                o.print_value = arch_regs[x.rd];
            end
            CMD_READ: arch_regs[x.rd] = x.data;
            default: ;
        endcase
        o.halted = (o.next_pc >= prog_len);
        return o;
    endfunction

    function automatic t_instr op(int cmd, int pc, int rd, int ra, int rb, int addr,
                                  int cond, int target, int data);
        t_instr x;
        x.cmd    = CMD_W'(cmd);
        x.pc     = PC_W'(pc);
        x.rd     = REG_AW'(rd);
        x.ra     = REG_AW'(ra);
        x.rb     = REG_AW'(rb);
        x.addr   = MEM_AW'(addr);
        x.cond   = COND_W'(cond);
        x.target = PC_W'(target);
        x.data   = DATA_W'(data);
        return x;
    endfunction

    function automatic t_outcome known(int npc, bit halted, bit pvalid, int pvalue);
        t_outcome o;
        o.next_pc     = NPC_W'(npc);
        o.halted      = halted;
        o.print_valid = pvalid;
        o.print_value = DATA_W'(pvalue);
        return o;
    endfunction

    function automatic t_instr random_instr();
        t_instr x;
        if ($urandom_range(0, 19) == 0) begin
            x.cmd = CMD_W'($urandom_range(CMD_UNDEF_FIRST, CMD_UNDEF_LAST));
        end else begin
            x.cmd = CMD_W'($urandom_range(CMD_PRELOAD, CMD_READ));
        end
        // mostly follow the program flow, sometimes jump anywhere
        x.pc     = ($urandom_range(0, 3) != 0) ? flow_pc : PC_W'($urandom_range(0, 127));
        x.rd     = REG_AW'($urandom_range(0, NUM_REGS - 1));
        x.ra     = REG_AW'($urandom_range(0, NUM_REGS - 1));
        x.rb     = REG_AW'($urandom_range(0, NUM_REGS - 1));
        // a small address pool so loads see earlier stores
        x.addr   = $urandom_range(0, 1) ? MEM_AW'($urandom_range(0, 15))
                                        : MEM_AW'($urandom_range(0, MEM_BYTES - 1));
        if ($urandom_range(0, 9) == 0) begin
            x.cond = COND_W'($urandom_range(COND_UNDEF_FIRST, COND_UNDEF_LAST));
        end else begin
            x.cond = COND_W'($urandom_range(COND_EQ, COND_GE));
        end
        x.target = PC_W'($urandom_range(0, 127));
        case ($urandom_range(0, 7))
            0: x.data = 8'h7f;
            1: x.data = 8'h80;
            2: x.data = 8'h00;
            3: x.data = 8'hff;
            default: x.data = DATA_W'($urandom_range(0, 255));
        endcase
        return x;
    endfunction

    task automatic issue(t_instr x, bit typed = 1'b0, t_outcome want = '0);
        t_outcome predicted;
        i_in_valid   <= 1'b1;
        i_command    <= x.cmd;
        i_pc         <= x.pc;
        i_dest_reg   <= x.rd;
        i_src_a_reg  <= x.ra;
        i_src_b_reg  <= x.rb;
        i_mem_addr   <= x.addr;
        i_condition  <= x.cond;
        i_target     <= x.target;
        i_data_value <= x.data;
        do @(posedge i_clk); while (o_in_stall);
        predicted = execute_instr(x);
        pending_results.push_back(typed ? want : predicted);
        flow_pc = predicted.next_pc[PC_W-1:0];
    endtask

    task automatic write_prog_len(logic [PLEN_W-1:0] len);
        i_cfg_valid          <= 1'b1;
        i_cfg_program_length <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        prog_len = len;
    endtask

    // also covers a result still in flight behind the last expected one
    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_items(int count);
        int burst;
        burst = $urandom_range(1, 24);
        repeat (count) begin
            issue(random_instr());
            burst--;
            if (burst == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst = $urandom_range(1, 24);
            end
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic check_field(string what, logic [7:0] want, logic [7:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected 0x%02h, got 0x%02h", $time, what, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got next_pc %0d",
                         $time, o_next_pc);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("next_pc", want.next_pc, o_next_pc);
                check_field("halted", 8'(want.halted), 8'(o_halted));
                check_field("print_valid", 8'(want.print_valid), 8'(o_print_valid));
                check_field("print_value", want.print_value, o_print_value);
            end
        end
    end

    // receiver stall pattern, switching among four styles at random
    int stall_mode = 0;
    int mode_left  = 0;
    int stall_tick = 0;

    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(50, 300);
        end
        mode_left--;
        stall_tick++;
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            2: i_out_stall <= ($urandom_range(0, 3) != 0);
            default: i_out_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    initial begin
        logic [PLEN_W-1:0] phase_len;
        foreach (arch_regs[i]) arch_regs[i] = '0;
        foreach (arch_mem[i]) arch_mem[i] = '0;
        prog_len = '0;
        flow_pc  = '0;

        // program length 100 during the directed part
        directed_plan.push_back('{op(CMD_PRINT, 5, 0, 0, 0, 0, COND_EQ, 0, 0),
                                  1'b1, known(6, 0, 1, 0)});
        directed_plan.push_back('{op(CMD_LOAD, 6, 1, 0, 0, 1023, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_PRELOAD, 0, 0, 0, 0, 0, COND_EQ, 0, 127),
                                  1'b1, known(0, 0, 0, 0)});
        directed_plan.push_back('{op(CMD_PRELOAD, 127, 7, 7, 7, 1023, COND_EQ, 127, -128),
                                  1'b1, known(127, 1, 0, 0)});
        directed_plan.push_back('{op(CMD_LOAD, 1, 2, 0, 0, 0, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_LOAD, 2, 3, 0, 0, 1023, COND_EQ, 0, 0), 1'b0, '0});
        // load result printed two requests after its load
        directed_plan.push_back('{op(CMD_PRINT, 3, 2, 0, 0, 0, COND_EQ, 0, 0),
                                  1'b1, known(4, 0, 1, 127)});
        directed_plan.push_back('{op(CMD_READ, 4, 4, 0, 0, 0, COND_EQ, 0, -1), 1'b0, '0});
        directed_plan.push_back('{op(CMD_ADD, 5, 5, 2, 4, 0, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_SUB, 6, 6, 3, 4, 0, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_MUL, 7, 7, 2, 2, 0, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_ADD, 8, 0, 2, 2, 0, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_STORE, 10, 3, 0, 0, 512, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_LOAD, 11, 1, 0, 0, 512, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_PRINT, 12, 1, 0, 0, 0, COND_EQ, 0, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_JUMP, 13, 0, 0, 0, 0, COND_EQ, 127, 0),
                                  1'b1, known(127, 1, 0, 0)});
        directed_plan.push_back('{op(CMD_JUMP, 127, 0, 0, 0, 0, COND_EQ, 0, 0),
                                  1'b1, known(0, 0, 0, 0)});
        directed_plan.push_back('{op(CMD_BRANCH, 20, 2, 0, 3, 0, COND_EQ, 40, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_BRANCH, 21, 3, 0, 2, 0, COND_LT, 41, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_BRANCH, 22, 3, 0, 2, 0, COND_GT, 42, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_BRANCH, 23, 2, 0, 2, 0, COND_LE, 43, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_BRANCH, 24, 3, 0, 2, 0, COND_GE, 44, 0), 1'b0, '0});
        directed_plan.push_back('{op(CMD_BRANCH, 127, 2, 0, 3, 0, COND_UNDEF_LAST, 5, 0),
                                  1'b1, known(128, 1, 0, 0)});
        directed_plan.push_back('{op(CMD_UNDEF_LAST, 126, 0, 0, 0, 0, COND_EQ, 0, 0),
                                  1'b1, known(127, 1, 0, 0)});
        directed_plan.push_back('{op(CMD_UNDEF_FIRST, 99, 0, 0, 0, 0, COND_EQ, 0, 0),
                                  1'b1, known(100, 1, 0, 0)});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_prog_len(8'd100);

        foreach (directed_plan[i]) begin
            issue(directed_plan[i].ins, directed_plan[i].typed, directed_plan[i].want);
        end
        i_in_valid <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: phase_len = 8'd128;
                1: phase_len = 8'd0;
                2: phase_len = 8'd255;
                3: phase_len = 8'd1;
                default: phase_len = PLEN_W'($urandom_range(0, 128));
            endcase
            write_prog_len(phase_len);
            run_items(ITEMS_PER_PHASE);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
